FILE: hdl/ffaa_pkg.sv
// shared types, constants and helper functions of the first-fit arena allocator
// no dependencies
`default_nettype none

package ffaa_pkg;

    localparam int ARENA_BYTES    = 65536;
    localparam int HDR_SPAN       = 16;
    localparam int ALIGN_BYTES    = 8;
    localparam int TAIL_MIN_BYTES = 16;
    localparam int LEN_W          = 17;
    localparam int OFF_W          = 16;
    localparam int END_W          = 18;
    localparam int SLOT_W         = 13;
    localparam int DEPTH          = ARENA_BYTES / ALIGN_BYTES;
    localparam int CNT_W          = 32;
    localparam int IN_W           = 56;
    localparam int OUT_W          = 200;

    typedef struct packed {
        logic [LEN_W-1:0] size;
        logic [OFF_W-1:0] prev;
        logic             free;
    } hdr_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_ACCEPT,
        OP_WALK_RD,
        OP_FIND_CHK,
        OP_TAKE_CHK,
        OP_TAIL_WR,
        OP_LNK_RD,
        OP_LNK_WR,
        OP_OWN_WR,
        OP_REL_RD,
        OP_REL_CHK,
        OP_MN_CHK,
        OP_PRV_RD,
        OP_MP_CHK,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [1:0] {
        RES_NULL,
        RES_SAME,
        RES_NEW,
        RES_MOVE
    } res_sel_t;

    typedef struct packed {
        dp_op_t   op;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic nsz_zero;
        logic has_ptr;
        logic rd_free;
        logic match;
        logic size_ge_want;
        logic split_ok;
        logic walk_end_ge;
        logic end_past_ptr;
        logic tail_in;
        logic rel_in;
        logic mn_in;
        logic mp_in;
        logic blk_zero;
        logic out_free;
    } dp_stat_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = (v > LEN_W'(ARENA_BYTES)) ? LEN_W'(ARENA_BYTES) : v;
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] head_size(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] s;
        s = sat_len(v);
        return (s > LEN_W'(HDR_SPAN)) ? (s - LEN_W'(HDR_SPAN)) : '0;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ffaa_dp.sv
// datapath of the arena allocator: header memory, walk registers, statistics, result register
// depends on ffaa_pkg
`default_nettype none

module ffaa_dp
    import ffaa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_data,
    input  wire logic [IN_W-1:0]  in_data,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic [OUT_W-1:0]      m_tdata,
    input  wire dp_cmd_t          cmd,
    output dp_stat_t              stat
);

    hdr_t mem [DEPTH];

    logic [LEN_W-1:0] len_reg, in_use_reg, peak_reg;
    logic [CNT_W-1:0] alloc_reg, rel_reg, fail_reg;
    logic             has_ptr_reg;
    logic [OFF_W-1:0] poff_reg, osz_reg, nsz_reg;
    logic [LEN_W-1:0] want_reg;
    logic [OFF_W-1:0] off_reg, blk_reg, np_reg, cur_prev_reg, lnk_prev_reg;
    logic [LEN_W-1:0] cur_size_reg;
    logic [END_W-1:0] lnk_addr_reg;
    hdr_t             rd_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic             mem_we, mem_re;
    logic [SLOT_W-1:0] mem_wa, mem_ra;
    hdr_t             mem_wd;

    logic [END_W-1:0] walk_end, rel_end, mn_end, mp_end, tail_end, len_x;
    logic [LEN_W-1:0] merge_size, new_use, in_want;
    logic [OFF_W-1:0] tail;
    logic [OFF_W-1:0] copy_len;
    logic             take_fit;

    assign len_x      = END_W'(len_reg);
    assign walk_end   = END_W'(off_reg) + END_W'(HDR_SPAN) + END_W'(rd_reg.size);
    assign rel_end    = END_W'(blk_reg) + END_W'(HDR_SPAN) + END_W'(rd_reg.size);
    assign merge_size = cur_size_reg + LEN_W'(HDR_SPAN) + rd_reg.size;
    assign mn_end     = END_W'(blk_reg) + END_W'(HDR_SPAN) + END_W'(merge_size);
    assign mp_end     = END_W'(cur_prev_reg) + END_W'(HDR_SPAN) + END_W'(merge_size);
    assign tail_end   = END_W'(off_reg) + END_W'(HDR_SPAN) + END_W'(cur_size_reg);
    assign tail       = OFF_W'(END_W'(off_reg) + END_W'(HDR_SPAN) + END_W'(want_reg));
    assign new_use    = in_use_reg + cur_size_reg;
    assign in_want    = (LEN_W'(in_data[48:33]) + LEN_W'(ALIGN_BYTES - 1))
                        & ~LEN_W'(ALIGN_BYTES - 1);
    assign take_fit   = rd_reg.free && (rd_reg.size >= want_reg);
    assign copy_len   = (osz_reg < nsz_reg) ? osz_reg : nsz_reg;

    always_comb begin
        stat.nsz_zero     = (nsz_reg == '0);
        stat.has_ptr      = has_ptr_reg;
        stat.rd_free      = rd_reg.free;
        stat.match        = (END_W'(off_reg) + END_W'(HDR_SPAN)) == END_W'(poff_reg);
        stat.size_ge_want = rd_reg.size >= want_reg;
        stat.split_ok     = END_W'(rd_reg.size)
                            >= END_W'(want_reg) + END_W'(HDR_SPAN + TAIL_MIN_BYTES);
        stat.walk_end_ge  = walk_end >= len_x;
        stat.end_past_ptr = (walk_end + END_W'(HDR_SPAN)) > END_W'(poff_reg);
        stat.tail_in      = tail_end < len_x;
        stat.rel_in       = rel_end < len_x;
        stat.mn_in        = mn_end < len_x;
        stat.mp_in        = mp_end < len_x;
        stat.blk_zero     = (blk_reg == '0);
        stat.out_free     = !out_valid_reg || m_tready;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = '0;
        if (cfg_we) begin
            mem_we = 1'b1;
            mem_wd = '{size: head_size(cfg_data), prev: '0, free: 1'b1};
        end else begin
            case (cmd.op)
                OP_INIT: begin
                    mem_we = 1'b1;
                    mem_wd = '{size: head_size(len_reg), prev: '0, free: 1'b1};
                end
                OP_WALK_RD: begin
                    mem_re = 1'b1;
                    mem_ra = off_reg[OFF_W-1:3];
                end
                OP_TAIL_WR: begin
                    mem_we = 1'b1;
                    mem_wa = tail[OFF_W-1:3];
                    mem_wd = '{size: cur_size_reg - want_reg - LEN_W'(HDR_SPAN),
                               prev: off_reg, free: 1'b1};
                end
                OP_LNK_RD: begin
                    mem_re = 1'b1;
                    mem_ra = lnk_addr_reg[OFF_W-1:3];
                end
                OP_LNK_WR: begin
                    mem_we = 1'b1;
                    mem_wa = lnk_addr_reg[OFF_W-1:3];
                    mem_wd = '{size: rd_reg.size, prev: lnk_prev_reg, free: rd_reg.free};
                end
                OP_OWN_WR: begin
                    mem_we = 1'b1;
                    mem_wa = off_reg[OFF_W-1:3];
                    mem_wd = '{size: cur_size_reg, prev: cur_prev_reg, free: 1'b0};
                end
                OP_REL_RD: begin
                    mem_re = 1'b1;
                    mem_ra = blk_reg[OFF_W-1:3];
                end
                OP_REL_CHK: begin
                    mem_we = 1'b1;
                    mem_wa = blk_reg[OFF_W-1:3];
                    mem_wd = '{size: rd_reg.size, prev: rd_reg.prev, free: 1'b1};
                end
                OP_MN_CHK: begin
                    mem_we = rd_reg.free;
                    mem_wa = blk_reg[OFF_W-1:3];
                    mem_wd = '{size: merge_size, prev: cur_prev_reg, free: 1'b1};
                end
                OP_PRV_RD: begin
                    mem_re = 1'b1;
                    mem_ra = cur_prev_reg[OFF_W-1:3];
                end
                OP_MP_CHK: begin
                    mem_we = rd_reg.free;
                    mem_wa = cur_prev_reg[OFF_W-1:3];
                    mem_wd = '{size: merge_size, prev: rd_reg.prev, free: 1'b1};
                end
                default: begin
                end
            endcase
        end
    end

    // header memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_ra];
        end
    end

    // statistics and arena length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= LEN_W'(ARENA_BYTES);
            in_use_reg <= '0;
            peak_reg   <= '0;
            alloc_reg  <= '0;
            rel_reg    <= '0;
            fail_reg   <= '0;
        end else if (cfg_we) begin
            len_reg    <= sat_len(cfg_data);
            in_use_reg <= '0;
            peak_reg   <= '0;
            alloc_reg  <= '0;
            rel_reg    <= '0;
            fail_reg   <= '0;
        end else begin
            case (cmd.op)
                OP_TAKE_CHK: begin
                    if (!take_fit && (walk_end >= len_x)) begin
                        fail_reg <= fail_reg + 1'b1;
                    end
                end
                OP_OWN_WR: begin
                    in_use_reg <= new_use;
                    if (new_use > peak_reg) begin
                        peak_reg <= new_use;
                    end
                    alloc_reg <= alloc_reg + 1'b1;
                end
                OP_REL_CHK: begin
                    in_use_reg <= in_use_reg - rd_reg.size;
                    rel_reg    <= rel_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // request and walk registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                has_ptr_reg <= in_data[0];
                poff_reg    <= in_data[16:1];
                osz_reg     <= in_data[32:17];
                nsz_reg     <= in_data[48:33];
                want_reg    <= in_want;
                off_reg     <= '0;
            end
            OP_FIND_CHK: begin
                cur_size_reg <= rd_reg.size;
                cur_prev_reg <= rd_reg.prev;
                if (stat.match) begin
                    blk_reg <= off_reg;
                    off_reg <= '0;
                end else begin
                    off_reg <= walk_end[OFF_W-1:0];
                end
            end
            OP_TAKE_CHK: begin
                cur_size_reg <= rd_reg.size;
                cur_prev_reg <= rd_reg.prev;
                if (!take_fit) begin
                    off_reg <= walk_end[OFF_W-1:0];
                end
            end
            OP_TAIL_WR: begin
                lnk_addr_reg <= tail_end;
                lnk_prev_reg <= tail;
                cur_size_reg <= want_reg;
            end
            OP_OWN_WR: begin
                np_reg <= OFF_W'(END_W'(off_reg) + END_W'(HDR_SPAN));
            end
            OP_REL_CHK: begin
                cur_size_reg <= rd_reg.size;
                cur_prev_reg <= rd_reg.prev;
                lnk_addr_reg <= rel_end;
            end
            OP_MN_CHK: begin
                if (rd_reg.free) begin
                    cur_size_reg <= merge_size;
                    lnk_addr_reg <= mn_end;
                    lnk_prev_reg <= blk_reg;
                end
            end
            OP_MP_CHK: begin
                lnk_addr_reg <= mp_end;
                lnk_prev_reg <= cur_prev_reg;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_FINISH) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        out_data_next          = '0;
        out_data_next[98:65]   = {peak_reg, in_use_reg};
        out_data_next[130:99]  = alloc_reg;
        out_data_next[162:131] = rel_reg;
        out_data_next[194:163] = fail_reg;
        case (cmd.res_sel)
            RES_SAME: begin
                out_data_next[0]    = 1'b1;
                out_data_next[16:1] = poff_reg;
            end
            RES_NEW: begin
                out_data_next[0]    = 1'b1;
                out_data_next[16:1] = np_reg;
            end
            RES_MOVE: begin
                out_data_next[0]     = 1'b1;
                out_data_next[16:1]  = np_reg;
                out_data_next[32:17] = poff_reg;
                out_data_next[48:33] = np_reg;
                out_data_next[64:49] = copy_len;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FINISH) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: hdl/ffaa_ctrl.sv
// sequencer of the arena allocator: find, first-fit take, split, release and merge steps
// depends on ffaa_pkg
`default_nettype none

module ffaa_ctrl
    import ffaa_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [22:0] {
        S_INIT  = 23'h000001,
        S_IDLE  = 23'h000002,
        S_DISP  = 23'h000004,
        S_FRD   = 23'h000008,
        S_FCHK  = 23'h000010,
        S_TRD   = 23'h000020,
        S_TCHK  = 23'h000040,
        S_TAIL  = 23'h000080,
        S_TLRD  = 23'h000100,
        S_TLWR  = 23'h000200,
        S_OWN   = 23'h000400,
        S_RRD   = 23'h000800,
        S_RCHK  = 23'h001000,
        S_MNRD  = 23'h002000,
        S_MNCHK = 23'h004000,
        S_MLRD  = 23'h008000,
        S_MLWR  = 23'h010000,
        S_PRV   = 23'h020000,
        S_MPRD  = 23'h040000,
        S_MPCHK = 23'h080000,
        S_PLRD  = 23'h100000,
        S_PLWR  = 23'h200000,
        S_DONE  = 23'h400000
    } st_t;

    st_t      state_reg, state_next;
    res_sel_t res_reg, res_next;
    logic     rz_reg, rz_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            res_reg   <= RES_NULL;
            rz_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
            rz_reg    <= rz_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        res_next    = res_reg;
        rz_next     = rz_reg;
        cmd.op      = OP_NONE;
        cmd.res_sel = res_reg;
        unique case (state_reg)
            S_INIT: begin
                cmd.op     = OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                res_next = RES_NULL;
                rz_next  = 1'b0;
                if (stat.nsz_zero) begin
                    state_next = stat.has_ptr ? S_FRD : S_DONE;
                end else if (!stat.has_ptr) begin
                    state_next = S_TRD;
                end else begin
                    state_next = S_FRD;
                end
            end
            S_FRD: begin
                cmd.op     = OP_WALK_RD;
                state_next = S_FCHK;
            end
            S_FCHK: begin
                cmd.op = OP_FIND_CHK;
                if (stat.match) begin
                    if (stat.rd_free) begin
                        state_next = S_DONE;
                    end else if (stat.nsz_zero) begin
                        state_next = S_RRD;
                    end else if (stat.size_ge_want) begin
                        res_next   = RES_SAME;
                        state_next = S_DONE;
                    end else begin
                        rz_next    = 1'b1;
                        state_next = S_TRD;
                    end
                end else if (stat.walk_end_ge || stat.end_past_ptr) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_FRD;
                end
            end
            S_TRD: begin
                cmd.op     = OP_WALK_RD;
                state_next = S_TCHK;
            end
            S_TCHK: begin
                cmd.op = OP_TAKE_CHK;
                if (stat.rd_free && stat.size_ge_want) begin
                    state_next = stat.split_ok ? S_TAIL : S_OWN;
                end else if (stat.walk_end_ge) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_TRD;
                end
            end
            S_TAIL: begin
                cmd.op     = OP_TAIL_WR;
                state_next = stat.tail_in ? S_TLRD : S_OWN;
            end
            S_TLRD: begin
                cmd.op     = OP_LNK_RD;
                state_next = S_TLWR;
            end
            S_TLWR: begin
                cmd.op     = OP_LNK_WR;
                state_next = S_OWN;
            end
            S_OWN: begin
                cmd.op = OP_OWN_WR;
                if (rz_reg) begin
                    res_next   = RES_MOVE;
                    state_next = S_RRD;
                end else begin
                    res_next   = RES_NEW;
                    state_next = S_DONE;
                end
            end
            S_RRD: begin
                cmd.op     = OP_REL_RD;
                state_next = S_RCHK;
            end
            S_RCHK: begin
                cmd.op     = OP_REL_CHK;
                state_next = stat.rel_in ? S_MNRD : S_PRV;
            end
            S_MNRD: begin
                cmd.op     = OP_LNK_RD;
                state_next = S_MNCHK;
            end
            S_MNCHK: begin
                cmd.op     = OP_MN_CHK;
                state_next = (stat.rd_free && stat.mn_in) ? S_MLRD : S_PRV;
            end
            S_MLRD: begin
                cmd.op     = OP_LNK_RD;
                state_next = S_MLWR;
            end
            S_MLWR: begin
                cmd.op     = OP_LNK_WR;
                state_next = S_PRV;
            end
            S_PRV: begin
                state_next = stat.blk_zero ? S_DONE : S_MPRD;
            end
            S_MPRD: begin
                cmd.op     = OP_PRV_RD;
                state_next = S_MPCHK;
            end
            S_MPCHK: begin
                cmd.op     = OP_MP_CHK;
                state_next = (stat.rd_free && stat.mp_in) ? S_PLRD : S_DONE;
            end
            S_PLRD: begin
                cmd.op     = OP_LNK_RD;
                state_next = S_PLWR;
            end
            S_PLWR: begin
                cmd.op     = OP_LNK_WR;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/first_fit_arena_allocator_unit.sv
// top level of the first-fit arena allocator with coalescing
// depends on ffaa_pkg, ffaa_ctrl and ffaa_dp
//
// channel  direction  contents
// s_       in         request: has_pointer, pointer_offset, old_size, new_size
// m_       out        result: offset, copy command, usage statistics
// cfg_     in         arena_length write, reinitializes the chain
//
// a request passes accept, dispatch and finish, plus a read and a check per header
// visited in each walk of the block chain (find, then first-fit), plus the take, split,
// release and merge steps; the header memory serves one registered access per cycle
// after reset the init state writes the head header before the first request is taken
// the finish cycle waits while the previous result still sits unaccepted in the output register
// a finished result waits in the output register; a new request is taken meanwhile
`default_nettype none

module first_fit_arena_allocator_unit
    import ffaa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_data,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // has_pointer, pointer_offset, old_size, new_size, zero pad
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // result_valid, result_offset, copy_from, copy_to, copy_length,
    // bytes_in_use, peak_in_use, alloc_count, free_count, failure_count, zero pad
    output logic [OUT_W-1:0]      m_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ffaa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffaa_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_data  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

FILE: hdl/ffaa_checker.sv
// port-level checks of the arena allocator, bound to the top level
// depends on ffaa_pkg and first_fit_arena_allocator_unit
`default_nettype none

module ffaa_checker
    import ffaa_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    a_hold_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_peak : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[98:82] >= m_tdata[81:65]))
        else $error("peak below current usage");

    a_null : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[16:1] == '0) && (m_tdata[64:49] == '0))
        else $error("null result carries offset or copy");

    a_copy : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[64:49] != '0) |-> (m_tdata[48:33] == m_tdata[16:1]))
        else $error("copy target differs from result offset");

endmodule

bind first_fit_arena_allocator_unit ffaa_checker u_ffaa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: sim/tb_first_fit_arena_allocator_unit.sv
// testbench of first_fit_arena_allocator_unit: directed and random requests against a
// built-in first-fit chain predictor, results checked field by field on the m_ stream
// depends on ffaa_pkg and the allocator rtl
`default_nettype none

module tb_first_fit_arena_allocator_unit;
    import ffaa_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        bit        valid;
        bit [15:0] offset;
        bit [15:0] copy_from;
        bit [15:0] copy_to;
        bit [15:0] copy_length;
        bit [16:0] bytes_in_use;
        bit [16:0] peak_in_use;
        bit [31:0] alloc_count;
        bit [31:0] free_count;
        bit [31:0] failure_count;
    } alloc_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    bit            gaps_on = 1'b1;
    int            fail_total = 0;
    int unsigned   cycle_count = 0;
    alloc_result_t results_pending[$];
    int unsigned   live_blocks[$];
    int unsigned   dead_blocks[$];

    // chain predictor state
    int unsigned hdr_size[DEPTH];
    int unsigned hdr_prev[DEPTH];
    bit          hdr_free[DEPTH];
    int unsigned chain_len;
    int unsigned used_bytes;
    int unsigned peak_bytes;
    bit [31:0]   n_alloc;
    bit [31:0]   n_free;
    bit [31:0]   n_fail;

    first_fit_arena_allocator_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned slot_of(int unsigned off);
        return (off / ALIGN_BYTES) % DEPTH;
    endfunction

    function automatic int unsigned end_of(int unsigned off);
        return off + HDR_SPAN + hdr_size[slot_of(off)];
    endfunction

    function automatic int unsigned round_up(int unsigned n);
        return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic void init_chain(int unsigned len);
        if (len > ARENA_BYTES) len = ARENA_BYTES;
        chain_len = len;
        used_bytes = 0;
        peak_bytes = 0;
        n_alloc = 0;
        n_free = 0;
        n_fail = 0;
        hdr_size[0] = (len > HDR_SPAN) ? len - HDR_SPAN : 0;
        hdr_prev[0] = 0;
        hdr_free[0] = 1'b1;
    endfunction

    function automatic void split_at(int unsigned off, int unsigned want);
        int unsigned s;
        int unsigned tail;
        int unsigned nxt;
        s = hdr_size[slot_of(off)];
        if (s < want + HDR_SPAN + TAIL_MIN_BYTES) return;
        tail = off + HDR_SPAN + want;
        hdr_size[slot_of(tail)] = s - want - HDR_SPAN;
        hdr_free[slot_of(tail)] = 1'b1;
        hdr_prev[slot_of(tail)] = off;
        nxt = end_of(tail);
        if (nxt < chain_len) hdr_prev[slot_of(nxt)] = tail;
        hdr_size[slot_of(off)] = want;
    endfunction

    function automatic void coalesce(int unsigned off);
        int unsigned nxt;
        int unsigned p;
        nxt = end_of(off);
        if (nxt < chain_len && hdr_free[slot_of(nxt)]) begin
            hdr_size[slot_of(off)] += HDR_SPAN + hdr_size[slot_of(nxt)];
            nxt = end_of(off);
            if (nxt < chain_len) hdr_prev[slot_of(nxt)] = off;
        end
        if (off != 0) begin
            p = hdr_prev[slot_of(off)];
            if (hdr_free[slot_of(p)]) begin
                hdr_size[slot_of(p)] += HDR_SPAN + hdr_size[slot_of(off)];
                nxt = end_of(p);
                if (nxt < chain_len) hdr_prev[slot_of(nxt)] = p;
            end
        end
    endfunction

    function automatic bit first_fit(int unsigned n, output int unsigned payload);
        int unsigned want;
        int unsigned off;
        int unsigned k;
        want = round_up(n);
        off = 0;
        payload = 0;
        forever begin
            k = slot_of(off);
            if (hdr_free[k] && hdr_size[k] >= want) begin
                split_at(off, want);
                hdr_free[k] = 1'b0;
                used_bytes += hdr_size[k];
                if (used_bytes > peak_bytes) peak_bytes = used_bytes;
                n_alloc++;
                payload = off + HDR_SPAN;
                return 1'b1;
            end
            off = end_of(off);
            if (off >= chain_len) break;
        end
        n_fail++;
        return 1'b0;
    endfunction

    function automatic bit locate(int unsigned poff, output int unsigned blk);
        int unsigned off;
        off = 0;
        blk = 0;
        forever begin
            if (off + HDR_SPAN == poff) begin
                if (hdr_free[slot_of(off)]) return 1'b0;
                blk = off;
                return 1'b1;
            end
            off = end_of(off);
            if (off >= chain_len || off + HDR_SPAN > poff) return 1'b0;
        end
    endfunction

    function automatic void release_at(int unsigned off);
        used_bytes -= hdr_size[slot_of(off)];
        n_free++;
        hdr_free[slot_of(off)] = 1'b1;
        coalesce(off);
    endfunction

    function automatic alloc_result_t predict_request(bit has_ptr, int unsigned poff,
                                                      int unsigned osz, int unsigned nsz);
        alloc_result_t r;
        int unsigned   blk;
        int unsigned   np;
        int unsigned   res;
        r = '{default: 0};
        res = 0;
        if (nsz == 0) begin
            if (has_ptr && locate(poff, blk)) release_at(blk);
        end else if (!has_ptr) begin
            r.valid = first_fit(nsz, res);
        end else if (locate(poff, blk)) begin
            if (hdr_size[slot_of(blk)] >= round_up(nsz)) begin
                r.valid = 1'b1;
                res = poff;
            end else if (first_fit(nsz, np)) begin
                r.valid = 1'b1;
                res = np;
                r.copy_from = poff;
                r.copy_to = np;
                r.copy_length = (osz < nsz) ? osz : nsz;
                release_at(blk);
            end
        end
        r.offset = r.valid ? res[15:0] : 16'd0;
        r.bytes_in_use = used_bytes[16:0];
        r.peak_in_use = peak_bytes[16:0];
        r.alloc_count = n_alloc;
        r.free_count = n_free;
        r.failure_count = n_fail;
        return r;
    endfunction

    task automatic send_request(input bit has_ptr, input int unsigned poff,
                                input int unsigned osz, input int unsigned nsz,
                                output alloc_result_t r);
        if (gaps_on && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 19) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, nsz[15:0], osz[15:0], poff[15:0], has_ptr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_request(has_ptr, poff, osz, nsz);
        results_pending.push_back(r);
    endtask

    task automatic set_arena(input int unsigned len);
        s_tvalid <= 1'b0;
        wait (results_pending.size() == 0);
        repeat (30) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_data <= len[16:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        init_chain(len[16:0]);
        live_blocks.delete();
        dead_blocks.delete();
        @(posedge aclk);
    endtask

    task automatic test_directed;
        alloc_result_t a;
        alloc_result_t b;
        alloc_result_t c;
        alloc_result_t r;
        send_request(1'b0, 16'hFFFF, 16'hFFFF, 0, r);
        send_request(1'b1, 16'hFFFF, 0, 0, r);
        send_request(1'b0, 0, 0, 1, a);
        send_request(1'b0, 0, 0, 24, b);
        send_request(1'b0, 0, 0, 40, c);
        send_request(1'b0, 0, 0, 16'hFFFF, r);
        send_request(1'b1, b.offset, 24, 20, r);
        send_request(1'b1, b.offset, 24, 200, b);
        send_request(1'b1, 16'h0005, 16'hFFFF, 8, r);
        send_request(1'b1, a.offset, 0, 0, r);
        send_request(1'b1, a.offset, 0, 0, r);
        send_request(1'b1, a.offset, 8, 64, r);
        send_request(1'b1, c.offset, 40, 0, r);
        send_request(1'b1, b.offset, 0, 0, r);
        send_request(1'b0, 0, 0, 65536 - HDR_SPAN, r);
        send_request(1'b1, r.offset, 16'hFFFF, 16'hFFFF, r);
        set_arena(96);
        send_request(1'b0, 0, 0, 40, a);
        send_request(1'b1, a.offset, 40, 48, r);
        send_request(1'b1, a.offset, 16'hFFFF, 80, r);
        send_request(1'b0, 0, 0, 8, r);
    endtask

    task automatic test_arena_limits;
        alloc_result_t r;
        int unsigned   lens[5] = '{0, HDR_SPAN, 32, 17'h1FFFF, 65536};
        foreach (lens[i]) begin
            set_arena(lens[i]);
            send_request(1'b0, 0, 0, 1, r);
            send_request(1'b0, 0, 0, 16, r);
            send_request(1'b1, r.offset, 16, 0, r);
        end
    endtask

    task automatic test_random(input int unsigned len, input int unsigned count,
                               input bit gaps);
        alloc_result_t r;
        int unsigned   pick;
        int unsigned   idx;
        int unsigned   ptr;
        int unsigned   sz;
        gaps_on = gaps;
        set_arena(len);
        repeat (count) begin
            pick = $urandom_range(99);
            if (live_blocks.size() > 30 && pick < 40) pick = 50;
            if (live_blocks.size() == 0 && pick >= 40 && pick < 85) pick = 0;
            if (pick < 40) begin
                sz = ($urandom_range(99) < 12) ? $urandom_range(65535)
                                              : $urandom_range(128, 1);
                send_request(1'b0, $urandom_range(65535), $urandom_range(65535), sz, r);
                if (r.valid) live_blocks.push_back(r.offset);
            end else if (pick < 65) begin
                idx = $urandom_range(live_blocks.size() - 1);
                ptr = live_blocks[idx];
                send_request(1'b1, ptr, $urandom_range(65535), 0, r);
                live_blocks.delete(idx);
                dead_blocks.push_back(ptr);
            end else if (pick < 85) begin
                idx = $urandom_range(live_blocks.size() - 1);
                ptr = live_blocks[idx];
                sz = ($urandom_range(99) < 8) ? $urandom_range(65535, 1)
                                             : $urandom_range(256, 1);
                send_request(1'b1, ptr, $urandom_range(300), sz, r);
                if (r.valid) live_blocks[idx] = r.offset;
            end else begin
                // stray pointers, null frees and freed blocks
                if (dead_blocks.size() > 0 && $urandom_range(1))
                    ptr = dead_blocks[$urandom_range(dead_blocks.size() - 1)];
                else
                    ptr = $urandom_range(65535);
                sz = $urandom_range(1) ? 0 : $urandom_range(65535);
                foreach (live_blocks[i]) if (live_blocks[i] == ptr) sz = 0;
                if (sz == 0 && ptr inside {live_blocks})
                    send_request(1'b0, ptr, $urandom_range(65535), 0, r);
                else
                    send_request(1'b1, ptr, $urandom_range(65535), sz, r);
            end
        end
        gaps_on = 1'b1;
    endtask

    function automatic alloc_result_t unpack_result(logic [OUT_W-1:0] d);
        alloc_result_t r;
        r.valid = d[0];
        r.offset = d[16:1];
        r.copy_from = d[32:17];
        r.copy_to = d[48:33];
        r.copy_length = d[64:49];
        r.bytes_in_use = d[81:65];
        r.peak_in_use = d[98:82];
        r.alloc_count = d[130:99];
        r.free_count = d[162:131];
        r.failure_count = d[194:163];
        return r;
    endfunction

    always @(posedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(99) >= 19);
    end

    always @(posedge aclk) begin
        alloc_result_t got;
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_result(m_tdata);
            if (results_pending.size() == 0) begin
                $error("result with no request outstanding");
                fail_total++;
            end else begin
                want = results_pending.pop_front();
                if (got.valid !== want.valid) begin
                    $error("result_valid expected %0d got %0d", want.valid, got.valid);
                    fail_total++;
                end
                if (got.offset !== want.offset) begin
                    $error("result_offset expected %0d got %0d", want.offset, got.offset);
                    fail_total++;
                end
                if (got.copy_from !== want.copy_from) begin
                    $error("copy_from expected %0d got %0d", want.copy_from, got.copy_from);
                    fail_total++;
                end
                if (got.copy_to !== want.copy_to) begin
                    $error("copy_to expected %0d got %0d", want.copy_to, got.copy_to);
                    fail_total++;
                end
                if (got.copy_length !== want.copy_length) begin
                    $error("copy_length expected %0d got %0d", want.copy_length,
                           got.copy_length);
                    fail_total++;
                end
                if (got.bytes_in_use !== want.bytes_in_use) begin
                    $error("bytes_in_use expected %0d got %0d", want.bytes_in_use,
                           got.bytes_in_use);
                    fail_total++;
                end
                if (got.peak_in_use !== want.peak_in_use) begin
                    $error("peak_in_use expected %0d got %0d", want.peak_in_use,
                           got.peak_in_use);
                    fail_total++;
                end
                if (got.alloc_count !== want.alloc_count) begin
                    $error("alloc_count expected %0d got %0d", want.alloc_count,
                           got.alloc_count);
                    fail_total++;
                end
                if (got.free_count !== want.free_count) begin
                    $error("free_count expected %0d got %0d", want.free_count,
                           got.free_count);
                    fail_total++;
                end
                if (got.failure_count !== want.failure_count) begin
                    $error("failure_count expected %0d got %0d", want.failure_count,
                           got.failure_count);
                    fail_total++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("first_fit_arena_allocator_unit test failed");
            $finish;
        end
    end

    initial begin
        init_chain(65536);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_arena_limits();
        test_random(4096, 200, 1'b1);
        test_random(1024, 150, 1'b0);
        test_random(65536, 200, 1'b1);
        test_random(300, 100, 1'b1);
        test_random(32 + $urandom_range(8000), 80, 1'b1);
        s_tvalid <= 1'b0;
        wait (results_pending.size() == 0);
        repeat (50) @(posedge aclk);
        if (fail_total == 0)
            $display("first_fit_arena_allocator_unit test passed");
        else
            $display("first_fit_arena_allocator_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/ffaa_pkg.sv
hdl/ffaa_dp.sv
hdl/ffaa_ctrl.sv
hdl/first_fit_arena_allocator_unit.sv
hdl/ffaa_checker.sv
sim/tb_first_fit_arena_allocator_unit.sv
